// ===== hw/rtl/utfn_pkg.sv =====
// shared types and constants for the utf wide-to-byte narrower
// no dependencies; imported by the front, queue, back and top modules
package utfn_pkg;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned CNT_W          = 16;
  localparam int unsigned MODE_W         = 3;
  localparam int unsigned PH_W           = 2;
  localparam int unsigned FIFO_DEPTH_DEF = 4;

  // charset codes
  localparam logic [MODE_W-1:0] CS_NONE   = 3'd0;
  localparam logic [MODE_W-1:0] CS_DETECT = 3'd1;
  localparam logic [MODE_W-1:0] CS_U16LE  = 3'd2;
  localparam logic [MODE_W-1:0] CS_U16BE  = 3'd3;
  localparam logic [MODE_W-1:0] CS_U32LE  = 3'd4;
  localparam logic [MODE_W-1:0] CS_U32BE  = 3'd5;

  // register indexes
  localparam logic CFG_CHARSET_MODE = 1'b0;
  localparam logic CFG_OUT_LIMIT    = 1'b1;

  // result kinds
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // everything one input beat causes: up to two data bytes and a summary
  typedef struct packed {
    logic [1:0]        n_data;
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic              has_sum;
    logic              sum_ok;
    logic [CNT_W-1:0]  sum_cnt;
  } bundle_t;

endpackage

// ===== hw/rtl/utfn_if.sv =====
// handshake channels of the narrower: raw byte input and result output
// no dependencies
interface utfn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, data_byte, end_of_buffer, input ready);
  modport sink   (input valid, data_byte, end_of_buffer, output ready);
endinterface

interface utfn_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  out_byte;
  logic        ok;
  logic [15:0] copied_count;
  logic        last;

  modport source (output valid, kind, out_byte, ok, copied_count, last, input ready);
  modport sink   (input valid, kind, out_byte, ok, copied_count, last, output ready);
endinterface

// ===== hw/rtl/utfn_front.sv =====
// front end: takes input beats and config writes, runs charset detection and
// narrowing, and pushes a result bundle for each beat that yields data or ends a buffer; uses utfn_pkg, utfn_in_if
module utfn_front import utfn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  utfn_in_if.sink           in_ch,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic              can_push,
  output logic              push,
  output bundle_t           push_data
);

  typedef struct packed {
    logic             emit;
    logic [PH_W-1:0]  phase;
    logic [CNT_W-1:0] cnt;
    logic             ok;
  } nstep_t;

  typedef struct packed {
    logic [MODE_W-1:0] cs;
    logic [2:0]        size;
  } pick_t;

  function automatic nstep_t narrow_step(input logic [MODE_W-1:0] cs,
                                         input logic [PH_W-1:0]   ph,
                                         input logic [CNT_W-1:0]  cnt,
                                         input logic [CNT_W-1:0]  lim,
                                         input logic              okb,
                                         input logic [BYTE_W-1:0] b);
    nstep_t r;
    logic   chk;
    r.emit  = 1'b0;
    r.phase = ph;
    r.cnt   = cnt;
    r.ok    = okb;
    chk     = 1'b0;
    if (cnt < lim) begin
      case (cs)
        CS_U16LE: begin
          if (ph == 2'd0) begin
            r.emit  = 1'b1;
            r.phase = 2'd1;
          end else begin
            chk     = 1'b1;
            r.phase = 2'd0;
          end
        end
        CS_U16BE: begin
          if (ph == 2'd0) begin
            chk     = 1'b1;
            r.phase = 2'd1;
          end else begin
            r.emit  = 1'b1;
            r.phase = 2'd0;
          end
        end
        CS_U32LE: begin
          r.emit  = (ph == 2'd0);
          chk     = (ph != 2'd0);
          r.phase = ph + 2'd1;
        end
        CS_U32BE: begin
          r.emit  = (ph == 2'd3);
          chk     = (ph != 2'd3);
          r.phase = ph + 2'd1;
        end
        default: ;
      endcase
    end
    if (r.emit) r.cnt = cnt + 16'd1;
    if (chk && (b != 8'h00)) r.ok = 1'b0;
    return r;
  endfunction

  // byte order mark first, then zero-byte pattern, then none
  function automatic pick_t pick_charset(input logic [BYTE_W-1:0] h0,
                                         input logic [BYTE_W-1:0] h1,
                                         input logic [BYTE_W-1:0] h2,
                                         input logic [BYTE_W-1:0] h3);
    pick_t p;
    p.size = 3'd0;
    if (h0 == 8'h00 && h1 == 8'h00 && h2 == 8'hFE && h3 == 8'hFF) begin
      p.cs = CS_U32BE; p.size = 3'd4;
    end else if (h0 == 8'hFF && h1 == 8'hFE && h2 == 8'h00 && h3 == 8'h00) begin
      p.cs = CS_U32LE; p.size = 3'd4;
    end else if (h0 == 8'hFE && h1 == 8'hFF) begin
      p.cs = CS_U16BE; p.size = 3'd2;
    end else if (h0 == 8'hFF && h1 == 8'hFE) begin
      p.cs = CS_U16LE; p.size = 3'd2;
    end else if (h0 == 8'h00 && h2 == 8'h00 && h3 != 8'h00) begin
      p.cs = (h1 != 8'h00) ? CS_U16BE : CS_U32BE;
    end else if (h0 != 8'h00 && h1 == 8'h00 && h3 == 8'h00) begin
      p.cs = (h2 != 8'h00) ? CS_U16LE : CS_U32LE;
    end else begin
      p.cs = CS_NONE;
    end
    return p;
  endfunction

  logic [CNT_W-1:0]  limit_r;
  logic [MODE_W-1:0] active_r, active_nxt;
  logic [PH_W-1:0]   phase_r, phase_nxt;
  logic [1:0]        hc_r, hc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ok_r, ok_nxt;
  logic [BYTE_W-1:0] held_r [3];
  logic              accept;
  logic              eob;
  logic [BYTE_W-1:0] b;

  assign in_ch.ready = can_push;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign eob         = in_ch.end_of_buffer;

  always_comb begin
    logic [BYTE_W-1:0] h [4];
    pick_t             pk;
    nstep_t            st;
    logic              data_left;
    logic [1:0]        nd;
    logic [BYTE_W-1:0] b0, b1;
    active_nxt = active_r;
    phase_nxt  = phase_r;
    hc_nxt     = hc_r;
    cnt_nxt    = cnt_r;
    ok_nxt     = ok_r;
    data_left  = 1'b1;
    nd         = 2'd0;
    b0         = '0;
    b1         = '0;
    h[0]       = held_r[0];
    h[1]       = held_r[1];
    h[2]       = held_r[2];
    h[3]       = b;
    pk         = pick_charset(h[0], h[1], h[2], h[3]);
    st         = '0;
    if (active_r == CS_DETECT) begin
      if (hc_r == 2'd3) begin
        // decision point: decode the held bytes and this byte past the stripped mark, from phase 0
        active_nxt = pk.cs;
        phase_nxt  = '0;
        hc_nxt     = '0;
        for (int i = 0; i < 4; i++) begin
          if (3'(i) >= pk.size) begin
            st = narrow_step(pk.cs, phase_nxt, cnt_nxt, limit_r, ok_nxt, h[i]);
            if (st.emit) begin
              if (nd == 2'd0) b0 = h[i];
              else            b1 = h[i];
              nd = nd + 2'd1;
            end
            phase_nxt = st.phase;
            cnt_nxt   = st.cnt;
            ok_nxt    = st.ok;
          end
        end
        data_left = (pk.size != 3'd4);
      end else begin
        hc_nxt = hc_r + 2'd1;
        if (eob) begin
          active_nxt = CS_NONE;
          phase_nxt  = '0;
          hc_nxt     = '0;
        end
      end
    end else begin
      st        = narrow_step(active_r, phase_r, cnt_r, limit_r, ok_r, b);
      phase_nxt = st.phase;
      cnt_nxt   = st.cnt;
      ok_nxt    = st.ok;
      if (st.emit) begin
        b0 = b;
        nd = 2'd1;
      end
    end

    push_data.n_data  = nd;
    push_data.byte0   = b0;
    push_data.byte1   = b1;
    push_data.has_sum = eob;
    push_data.sum_ok  = ok_nxt && data_left;
    push_data.sum_cnt = cnt_nxt;
    if (eob) begin
      cnt_nxt = '0;
      ok_nxt  = 1'b1;
    end
  end

  assign push = accept && ((push_data.n_data != 2'd0) || eob);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= '1;
      active_r <= CS_NONE;
      phase_r  <= '0;
      hc_r     <= '0;
      cnt_r    <= '0;
      ok_r     <= 1'b1;
    end else begin
      if (accept) begin
        active_r <= active_nxt;
        phase_r  <= phase_nxt;
        hc_r     <= hc_nxt;
        cnt_r    <= cnt_nxt;
        ok_r     <= ok_nxt;
      end
      // mode write drops held bytes but keeps the buffer counters
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHARSET_MODE: begin
            active_r <= cfg_wdata[MODE_W-1:0];
            phase_r  <= '0;
            hc_r     <= '0;
          end
          CFG_OUT_LIMIT: limit_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (active_r == CS_DETECT) && (hc_r != 2'd3)) held_r[hc_r] <= b;
  end

endmodule

// ===== hw/rtl/utfn_fifo.sv =====
// short bundle queue between the front and back ends
// uses utfn_pkg for the bundle type
module utfn_fifo import utfn_pkg::*; #(
  parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output bundle_t head,
  output logic    not_full,
  output logic    not_empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bundle_t         mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign not_full  = (count_r != CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + CW'(1);
    if (!do_push && do_pop) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_data;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> not_full) else $error("bundle pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("pop from an empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

// ===== hw/rtl/utfn_back.sv =====
// back end: unpacks one bundle into its result beats on the output channel
// uses utfn_pkg and utfn_out_if
module utfn_back import utfn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  bundle_t  head,
  input  logic     have_head,
  output logic     pop,
  utfn_out_if.source out_ch
);

  bundle_t    cur_r;
  logic       cur_valid_r;
  logic [1:0] idx_r;
  logic [1:0] total;
  logic       is_data;
  logic       is_last;
  logic       fire;
  logic       done;

  assign total   = cur_r.n_data + {1'b0, cur_r.has_sum};
  assign is_data = (idx_r < cur_r.n_data);
  assign is_last = (idx_r == total - 2'd1);
  assign fire    = cur_valid_r && out_ch.ready;
  assign done    = fire && is_last;
  assign pop     = have_head && (!cur_valid_r || done);

  assign out_ch.valid        = cur_valid_r;
  assign out_ch.kind         = is_data ? KIND_DATA : KIND_SUMMARY;
  assign out_ch.out_byte     = is_data ? ((idx_r == 2'd0) ? cur_r.byte0 : cur_r.byte1) : '0;
  assign out_ch.ok           = is_data ? 1'b0 : cur_r.sum_ok;
  assign out_ch.copied_count = is_data ? '0 : cur_r.sum_cnt;
  assign out_ch.last         = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (done) begin
      cur_valid_r <= 1'b0;
    end else if (fire) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_r <= head;
  end

`ifndef SYNTHESIS
  a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (idx_r < total)) else $error("result index past bundle end");
  a_summary_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == KIND_SUMMARY) |-> out_ch.last)
    else $error("summary beat not last of its input");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r && !out_ch.ready) |=> (cur_valid_r && $stable(idx_r)))
    else $error("bundle position moved while stalled");
`endif

endmodule

// ===== hw/rtl/utf_wide_to_byte_narrower_core.sv =====
// top level of the utf-16/32 to byte narrower with mark detection
// uses utfn_pkg, utfn_if, utfn_front, utfn_fifo and utfn_back
//
//  channel   direction  beat contents
//  in_ch     sink       data_byte, end_of_buffer
//  out_ch    source     kind, out_byte, ok, copied_count, last
//  cfg_*     write      cfg_index 0 charset_mode, 1 out_limit
//
// one input beat per cycle while the bundle queue has room; each beat is
// classified and narrowed combinationally by the front end
// the back end sends one result per cycle while out_ch.ready is high, so a beat with three results
// holds the output until all three are sent; FIFO_DEPTH bundles absorb this
// reset is synchronous; no clearing pass
// an output stall fills the queue, then in_ch.ready drops
module utf_wide_to_byte_narrower_core import utfn_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  utfn_in_if.sink          in_ch,
  utfn_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CNT_W-1:0] cfg_wdata
);

  bundle_t push_data;
  bundle_t head;
  logic    push;
  logic    pop;
  logic    not_full;
  logic    not_empty;

  utfn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .can_push  (not_full),
    .push      (push),
    .push_data (push_data)
  );

  utfn_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_full  (not_full),
    .not_empty (not_empty)
  );

  utfn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .have_head (not_empty),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule
